// ===== hw/rtl/hgcs_pkg.sv =====
package hgcs_pkg;

    // font geometry
    localparam int GLYPH_ROWS        = 14;
    localparam int GLYPH_COUNT       = 95;
    localparam int MAX_GLYPH_COLUMNS = 16;

    // field widths
    localparam int ROW_W      = 16;
    localparam int COL_W      = 14;
    localparam int CHAR_W     = 8;
    localparam int ROW_IDX_W  = 4;
    localparam int REPEAT_W   = 2;

    // stream packing
    localparam int IN_DATA_W  = 32;
    localparam int IN_CHAR_LO = 0;
    localparam int IN_ROW_LO  = IN_CHAR_LO + CHAR_W;
    localparam int IN_BITS_LO = IN_ROW_LO + ROW_IDX_W;
    localparam int OUT_DATA_W = 16;

    // printable range
    localparam logic [CHAR_W-1:0] FIRST_CHAR = 8'd32;
    localparam logic [CHAR_W-1:0] LAST_CHAR  = 8'd126;

    // input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHAR  = 1'b1;

    // font store
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);

    // sequencing
    localparam int COL_USED    = (GLYPH_ROWS < COL_W) ? GLYPH_ROWS : COL_W;
    localparam int ROW_CNT_W   = $clog2(GLYPH_ROWS + 1);
    localparam int COL_CNT_W   = $clog2(MAX_GLYPH_COLUMNS + 1);
    localparam int SPACE_EXTRA = 3;
    localparam int SPACE_CNT_W = 2;

    // command queue, depth a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'b00,
        CMD_SPACE = 2'b01,
        CMD_GLYPH = 2'b10,
        CMD_BLANK = 2'b11
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [ROW_W-1:0]  data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/hgcs_ram.sv =====
module hgcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1330
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hgcs_front.sv =====
module hgcs_front (
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hgcs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  hgcs_pkg::queue_status_t        queue_status,
    output logic                           push,
    output hgcs_pkg::cmd_t                 cmd
);

    logic [hgcs_pkg::CHAR_W-1:0]      char_code;
    logic [hgcs_pkg::ROW_IDX_W-1:0]   row_index;
    logic [hgcs_pkg::ROW_W-1:0]       row_bits;
    logic                             printable;
    logic                             row_ok;
    logic                             drop;
    logic [hgcs_pkg::GLYPH_IDX_W-1:0] glyph_idx;
    logic [hgcs_pkg::ADDR_W-1:0]      base_addr;

    // field unpacking
    assign char_code = s_axis_tdata[hgcs_pkg::IN_CHAR_LO +: hgcs_pkg::CHAR_W];
    assign row_index = s_axis_tdata[hgcs_pkg::IN_ROW_LO +: hgcs_pkg::ROW_IDX_W];
    assign row_bits  = s_axis_tdata[hgcs_pkg::IN_BITS_LO +: hgcs_pkg::ROW_W];

    // range checks and glyph base address
    assign printable = (char_code >= hgcs_pkg::FIRST_CHAR) &&
                       (char_code <= hgcs_pkg::LAST_CHAR);
    assign row_ok    = int'(row_index) < hgcs_pkg::GLYPH_ROWS;
    assign glyph_idx = hgcs_pkg::GLYPH_IDX_W'(char_code - hgcs_pkg::FIRST_CHAR);
    assign base_addr = hgcs_pkg::ADDR_W'(glyph_idx) *
                       hgcs_pkg::ADDR_W'(hgcs_pkg::GLYPH_ROWS);

    // classify the item into a command
    always_comb
    begin
        cmd.data = row_bits;
        cmd.addr = base_addr;
        if (s_axis_tuser == hgcs_pkg::OP_WRITE)
        begin
            cmd.kind = hgcs_pkg::CMD_WRITE;
            cmd.addr = base_addr + hgcs_pkg::ADDR_W'(row_index);
        end
        else if (char_code == hgcs_pkg::FIRST_CHAR)
        begin
            cmd.kind = hgcs_pkg::CMD_SPACE;
        end
        else if (printable)
        begin
            cmd.kind = hgcs_pkg::CMD_GLYPH;
        end
        else
        begin
            cmd.kind = hgcs_pkg::CMD_BLANK;
        end
    end

    // writes outside the font are taken and discarded
    assign drop          = (s_axis_tuser == hgcs_pkg::OP_WRITE) && !(printable && row_ok);
    assign s_axis_tready = !queue_status.full;
    assign push          = s_axis_tvalid && s_axis_tready && !drop;

endmodule

// ===== hw/rtl/hgcs_cmd_queue.sv =====
module hgcs_cmd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  hgcs_pkg::cmd_t          cmd_in,
    input  logic                    pop,
    output hgcs_pkg::cmd_t          cmd_out,
    output hgcs_pkg::queue_status_t status
);

    hgcs_pkg::cmd_t                     slot_reg [hgcs_pkg::QUEUE_DEPTH];
    logic [hgcs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [hgcs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [hgcs_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [hgcs_pkg::QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [hgcs_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [hgcs_pkg::QUEUE_CNT_W-1:0]   count_next;

    // pointer and fill bookkeeping, pointers wrap naturally
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd_out      = slot_reg[rd_ptr_reg];
    assign status.full  = count_reg == hgcs_pkg::QUEUE_CNT_W'(hgcs_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hgcs_pkg::QUEUE_CNT_W'(hgcs_pkg::QUEUE_DEPTH))
        else $error("command queue holds more than its depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("command pushed into a full queue");
`endif

endmodule

// ===== hw/rtl/hgcs_back.sv =====
module hgcs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hgcs_pkg::queue_status_t         queue_status,
    input  hgcs_pkg::cmd_t                  cmd,
    output logic                            pop,
    input  logic [hgcs_pkg::REPEAT_W-1:0]   column_repeat,
    output logic                            ram_we,
    output logic [hgcs_pkg::ADDR_W-1:0]     ram_waddr,
    output logic [hgcs_pkg::ROW_W-1:0]      ram_wdata,
    output logic [hgcs_pkg::ADDR_W-1:0]     ram_raddr,
    input  logic [hgcs_pkg::ROW_W-1:0]      ram_rdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hgcs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LEAD  = 6'b000010,
        S_SPACE = 6'b000100,
        S_LOAD  = 6'b001000,
        S_COL   = 6'b010000,
        S_TRAIL = 6'b100000
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    hgcs_pkg::cmd_kind_t                  kind_reg;
    hgcs_pkg::cmd_kind_t                  kind_next;
    logic [hgcs_pkg::ADDR_W-1:0]          base_reg;
    logic [hgcs_pkg::ADDR_W-1:0]          base_next;
    logic [hgcs_pkg::ROW_CNT_W-1:0]       row_cnt_reg;
    logic [hgcs_pkg::ROW_CNT_W-1:0]       row_cnt_next;
    logic [hgcs_pkg::COL_CNT_W-1:0]       col_cnt_reg;
    logic [hgcs_pkg::COL_CNT_W-1:0]       col_cnt_next;
    logic [hgcs_pkg::REPEAT_W-1:0]        rep_cnt_reg;
    logic [hgcs_pkg::REPEAT_W-1:0]        rep_cnt_next;
    logic [hgcs_pkg::SPACE_CNT_W-1:0]     space_cnt_reg;
    logic [hgcs_pkg::SPACE_CNT_W-1:0]     space_cnt_next;
    logic [hgcs_pkg::ROW_W-1:0]           any_reg;
    logic [hgcs_pkg::ROW_W-1:0]           any_next;
    logic [hgcs_pkg::ROW_W-1:0]           rows_reg [hgcs_pkg::GLYPH_ROWS];
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [hgcs_pkg::COL_W-1:0]           out_bits_reg;
    logic [hgcs_pkg::COL_W-1:0]           out_bits_next;
    logic                                 out_last_reg;
    logic                                 out_last_next;

    logic                                 emit_ok;
    logic                                 emit;
    logic [hgcs_pkg::COL_W-1:0]           emit_bits;
    logic                                 emit_last;
    logic                                 capture;
    logic                                 shift;
    logic [hgcs_pkg::REPEAT_W-1:0]        reps;
    logic [hgcs_pkg::COL_W-1:0]           column_w;

    // a repeat of zero counts as one
    assign reps = (column_repeat == '0) ? hgcs_pkg::REPEAT_W'(1) : column_repeat;

    // current column is the top bit of every row, bottom row to bit 0
    always_comb
    begin
        column_w = '0;
        for (int b = 0; b < hgcs_pkg::COL_USED; b++)
        begin
            column_w[b] = rows_reg[hgcs_pkg::GLYPH_ROWS-1-b][hgcs_pkg::ROW_W-1];
        end
    end

    assign emit_ok   = !out_valid_reg || m_axis_tready;
    assign ram_waddr = cmd.addr;
    assign ram_wdata = cmd.data;
    assign ram_raddr = base_reg + hgcs_pkg::ADDR_W'(row_cnt_reg);

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        base_next      = base_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        rep_cnt_next   = rep_cnt_reg;
        space_cnt_next = space_cnt_reg;
        any_next       = any_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        emit           = 1'b0;
        emit_bits      = '0;
        emit_last      = 1'b0;
        capture        = 1'b0;
        shift          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!queue_status.empty)
                begin
                    pop = 1'b1;
                    if (cmd.kind == hgcs_pkg::CMD_WRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        kind_next  = cmd.kind;
                        base_next  = cmd.addr;
                        state_next = S_LEAD;
                    end
                end
            end
            S_LEAD:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    case (kind_reg)
                        hgcs_pkg::CMD_SPACE:
                        begin
                            space_cnt_next = '0;
                            state_next     = S_SPACE;
                        end
                        hgcs_pkg::CMD_GLYPH:
                        begin
                            row_cnt_next = '0;
                            any_next     = '0;
                            state_next   = S_LOAD;
                        end
                        default:
                        begin
                            state_next = S_TRAIL;
                        end
                    endcase
                end
            end
            S_SPACE:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    if (space_cnt_reg == hgcs_pkg::SPACE_CNT_W'(hgcs_pkg::SPACE_EXTRA - 1))
                    begin
                        state_next = S_TRAIL;
                    end
                    else
                    begin
                        space_cnt_next = space_cnt_reg + 1'b1;
                    end
                end
            end
            S_LOAD:
            begin
                // read data comes from the registered ram port in the cycle after its address
                row_cnt_next = row_cnt_reg + 1'b1;
                if (row_cnt_reg != '0)
                begin
                    capture  = 1'b1;
                    any_next = any_reg | ram_rdata;
                end
                if (row_cnt_reg == hgcs_pkg::ROW_CNT_W'(hgcs_pkg::GLYPH_ROWS))
                begin
                    row_cnt_next = row_cnt_reg;
                    col_cnt_next = '0;
                    rep_cnt_next = '0;
                    state_next   = S_COL;
                end
            end
            S_COL:
            begin
                // stop once nothing is left to the right or the maximum glyph width is reached
                if ((any_reg == '0) ||
                    (col_cnt_reg == hgcs_pkg::COL_CNT_W'(hgcs_pkg::MAX_GLYPH_COLUMNS)))
                begin
                    state_next = S_TRAIL;
                end
                else if (emit_ok)
                begin
                    emit      = 1'b1;
                    emit_bits = column_w;
                    if (rep_cnt_reg == reps - 1'b1)
                    begin
                        rep_cnt_next = '0;
                        col_cnt_next = col_cnt_reg + 1'b1;
                        shift        = 1'b1;
                        any_next     = any_reg << 1;
                    end
                    else
                    begin
                        rep_cnt_next = rep_cnt_reg + 1'b1;
                    end
                end
            end
            S_TRAIL:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bits_next  = out_bits_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_bits_next  = emit_bits;
            out_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= hgcs_pkg::CMD_BLANK;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            rep_cnt_reg   <= '0;
            space_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            rep_cnt_reg   <= rep_cnt_next;
            space_cnt_reg <= space_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        any_reg      <= any_next;
        out_bits_reg <= out_bits_next;
        out_last_reg <= out_last_next;
    end

    // glyph rows: shift line while loading, shift left per finished column
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int r = 0; r < hgcs_pkg::GLYPH_ROWS - 1; r++)
            begin
                rows_reg[r] <= rows_reg[r+1];
            end
            rows_reg[hgcs_pkg::GLYPH_ROWS-1] <= ram_rdata;
        end
        else if (shift)
        begin
            for (int r = 0; r < hgcs_pkg::GLYPH_ROWS; r++)
            begin
                rows_reg[r] <= rows_reg[r] << 1;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = hgcs_pkg::OUT_DATA_W'(out_bits_reg);
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_col_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COL) |->
            (col_cnt_reg <= hgcs_pkg::COL_CNT_W'(hgcs_pkg::MAX_GLYPH_COLUMNS)))
        else $error("column counter ran past the glyph width");
    a_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COL) |-> (row_cnt_reg == hgcs_pkg::ROW_CNT_W'(hgcs_pkg::GLYPH_ROWS)))
        else $error("column scan started before all rows were loaded");
    a_last_null: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_bits_reg == '0))
        else $error("trailing column is not blank");
`endif

endmodule

// ===== hw/rtl/hell_glyph_column_streamer_core.sv =====
// channel  | dir | handshake                      | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready  | tdata: char_code, row_index, row_bits; tuser: op
// m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata: column_bits; tlast: last_column
// cfg      | in  | cfg_wr_en                      | cfg_wr_data: column_repeat
//
// the front takes one item a cycle into a four-entry command queue while it has room
// a font row write pops the queue and writes the ram in the same back-end cycle
// a glyph character is paced by the 14 serial row reads from the single font ram read port
// and by one column emitted per cycle while m_axis accepts them
// reset clears control state and sets the repeat to one; the font ram is not cleared
// a stalled m_axis holds the sequencer in its emitting states; the input stalls only when the queue fills
module hell_glyph_column_streamer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // char_code [7:0], row_index [11:8], row_bits [27:12], zero [31:28]
    input  logic [hgcs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // column_bits [13:0], zero [15:14]
    output logic [hgcs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_wr_en,
    input  logic [hgcs_pkg::REPEAT_W-1:0]   cfg_wr_data
);

    logic [hgcs_pkg::REPEAT_W-1:0] column_repeat_reg;
    hgcs_pkg::queue_status_t       queue_status;
    hgcs_pkg::cmd_t                push_cmd;
    hgcs_pkg::cmd_t                head_cmd;
    logic                          push;
    logic                          pop;
    logic                          ram_we;
    logic [hgcs_pkg::ADDR_W-1:0]   ram_waddr;
    logic [hgcs_pkg::ROW_W-1:0]    ram_wdata;
    logic [hgcs_pkg::ADDR_W-1:0]   ram_raddr;
    logic [hgcs_pkg::ROW_W-1:0]    ram_rdata;

    // repeat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_repeat_reg <= hgcs_pkg::REPEAT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            column_repeat_reg <= cfg_wr_data;
        end
    end

    // classify incoming items
    hgcs_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_status  (queue_status),
        .push          (push),
        .cmd           (push_cmd)
    );

    // decoupling queue
    hgcs_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (push_cmd),
        .pop     (pop),
        .cmd_out (head_cmd),
        .status  (queue_status)
    );

    // font store
    hgcs_ram #(
        .WIDTH (hgcs_pkg::ROW_W),
        .DEPTH (hgcs_pkg::STORE_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // column sequencer and output register
    hgcs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_status  (queue_status),
        .cmd           (head_cmd),
        .pop           (pop),
        .column_repeat (column_repeat_reg),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
